@@ sv/debounced_button_with_repeat_defines.svh @@
// Assertion macros shared by the RTL
`ifndef DEBOUNCED_BUTTON_WITH_REPEAT_DEFINES_SVH
`define DEBOUNCED_BUTTON_WITH_REPEAT_DEFINES_SVH

// Checked only outside reset
`define DBR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checked on every edge, reset included
`define DBR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/dbr_pkg.sv @@
package dbr_pkg;

  // Width of the saturating millisecond counter
  localparam int unsigned CntW = 32;
  localparam int unsigned CfgW = 16;
  localparam int unsigned HeldW = 32;

  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [CfgW-1:0]  cfg_t;
  typedef logic [HeldW-1:0] held_t;

  localparam cnt_t  CntMax  = {CntW{1'b1}};
  localparam held_t HeldMax = {HeldW{1'b1}};

  // Register indexes
  localparam logic CfgIdxDebounce = 1'b0;
  localparam logic CfgIdxRepeat   = 1'b1;

  localparam cfg_t DebounceRst = cfg_t'(50);
  localparam cfg_t RepeatRst   = '0;

endpackage

@@ sv/debounced_button_with_repeat.sv @@
// Debounced button with auto-repeat. One input beat is one millisecond tick
// carrying the raw pin level and the take flags; every tick gives exactly one
// result beat. A new tick is taken every clock cycle unless in_stall_o holds it;
// each tick passes the input register, then the result register. The rate is
// set by the saturating counter update, a 32-bit increment and compare that
// must settle before the next tick, which builds on it. Configuration writes
// are taken in any cycle (ready is always high) and are meant for idle times.
module debounced_button_with_repeat (
  input  logic           clk_i,
  input  logic           rst_ni,
  // tick channel
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           raw_level_i,
  input  logic           take_rise_i,
  input  logic           take_fall_i,
  // result channel
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           pressed_o,
  output logic           rise_pending_o,
  output logic           fall_pending_o,
  output dbr_pkg::held_t held_ms_o,
  // register writes
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_index_i,
  input  dbr_pkg::cfg_t  cfg_data_i
);
  import dbr_pkg::*;

  `include "debounced_button_with_repeat_defines.svh"

  // Configuration registers
  cfg_t debounce_q, repeat_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DebounceRst;
      repeat_q   <= RepeatRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgIdxDebounce: debounce_q <= cfg_data_i;
        CfgIdxRepeat:   repeat_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake between the two stages
  logic s1_valid_q;
  logic out_valid_q;
  logic out_free;
  logic s1_fire;
  logic in_fire;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  // Input register
  logic raw_q, take_r_q, take_f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      raw_q    <= raw_level_i;
      take_r_q <= take_rise_i;
      take_f_q <= take_fall_i;
    end
  end

  // Button state
  logic level_q, level_d;
  cnt_t since_q, since_d;
  logic taken_q, taken_d;

  // Tick update
  cnt_t  since_inc;
  logic  accept;
  logic  rise, fall;
  held_t held;

  always_comb begin
    since_inc = (since_q == CntMax) ? since_q : since_q + cnt_t'(1);
    if (raw_q == level_q) begin
      accept = level_q && (repeat_q != '0) && (since_inc >= cnt_t'(repeat_q));
    end else begin
      accept = since_inc >= cnt_t'(debounce_q);
    end
    level_d = accept ? raw_q : level_q;
    since_d = accept ? '0 : since_inc;
    taken_d = accept ? 1'b0 : taken_q;
    rise    = level_d && !taken_d;
    fall    = !level_d && !taken_d;
    if ((take_r_q && rise) || (take_f_q && fall)) begin
      taken_d = 1'b1;
    end
    // clamp the count to the result width
    if (!level_d) begin
      held = '0;
    end else if (since_d > cnt_t'(HeldMax)) begin
      held = HeldMax;
    end else begin
      held = held_t'(since_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 1'b0;
      since_q <= '0;
      taken_q <= 1'b0;
    end else if (s1_fire) begin
      level_q <= level_d;
      since_q <= since_d;
      taken_q <= taken_d;
    end
  end

  // Result register
  logic  pressed_q, rise_q, fall_q;
  held_t held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      pressed_q <= level_d;
      rise_q    <= rise;
      fall_q    <= fall;
      held_q    <= held;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pressed_o      = pressed_q;
  assign rise_pending_o = rise_q;
  assign fall_pending_o = fall_q;
  assign held_ms_o      = held_q;

  // Checks
  `DBR_ASSERT(a_one_event, clk_i, rst_ni,
              !(out_valid_q && rise_q && fall_q),
              "rise and fall both pending")
  `DBR_ASSERT(a_held_released, clk_i, rst_ni,
              (out_valid_q && !pressed_q) |-> (held_q == '0),
              "held time while released")
  `DBR_ASSERT_ALWAYS(a_stall_cause, clk_i,
                     in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i),
                     "input stalled without a full pipe")
  `DBR_ASSERT(a_state_hold, clk_i, rst_ni,
              !$past(s1_fire) |-> ($stable(level_q) && $stable(taken_q) && $stable(since_q)),
              "state moved without a tick")

endmodule

@@ verif/debounced_button_with_repeat_tb.sv @@
module debounced_button_with_repeat_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dbr_pkg::*;

  // One tick result as seen on the output port
  typedef struct {
    logic  pressed;
    logic  rise;
    logic  fall;
    held_t held;
  } tick_result_t;

  logic  clk = 1'b0;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  logic  raw_level;
  logic  take_rise;
  logic  take_fall;
  logic  out_valid;
  logic  out_stall;
  logic  pressed;
  logic  rise_pending;
  logic  fall_pending;
  held_t held_ms;
  logic  cfg_valid;
  logic  cfg_ready;
  logic  cfg_index;
  cfg_t  cfg_data;

  // Button model state and its copy of the registers
  logic  btn_level;
  cnt_t  btn_ms;
  logic  btn_taken;
  cfg_t  debounce_cfg;
  cfg_t  repeat_cfg;

  tick_result_t pending_results[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int holdoff_left   = 0;
  int mismatches     = 0;
  int n_ticks        = 0;
  int n_checked      = 0;
  int n_writes       = 0;

  debounced_button_with_repeat uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .raw_level_i    (raw_level),
    .take_rise_i    (take_rise),
    .take_fall_i    (take_fall),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .pressed_o      (pressed),
    .rise_pending_o (rise_pending),
    .fall_pending_o (fall_pending),
    .held_ms_o      (held_ms),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic bit coin(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  // Advance the button model by one millisecond tick
  function automatic tick_result_t step_button(input logic raw, input logic tr, input logic tf);
    tick_result_t r;
    logic         accept;
    accept = 1'b0;
    if (btn_ms != CntMax) btn_ms = btn_ms + 1'b1;
    if (raw == btn_level) begin
      // held: repeat re-arms the press event
      if (btn_level && repeat_cfg != '0 && btn_ms >= cnt_t'(repeat_cfg)) accept = 1'b1;
    end else if (btn_ms >= cnt_t'(debounce_cfg)) begin
      accept = 1'b1;
    end
    if (accept) begin
      btn_level = raw;
      btn_ms    = '0;
      btn_taken = 1'b0;
    end
    r.pressed = btn_level;
    r.rise    = btn_level && !btn_taken;
    r.fall    = !btn_level && !btn_taken;
    if ((tr && r.rise) || (tf && r.fall)) btn_taken = 1'b1;
    r.held = '0;
    if (btn_level) r.held = (btn_ms > cnt_t'(HeldMax)) ? HeldMax : held_t'(btn_ms);
    return r;
  endfunction

  // Offer one tick beat; entered and left at a falling edge
  task automatic send_tick(input logic raw, input logic tr, input logic tf);
    if (send_idle_pct != 0 && coin(send_idle_pct)) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid  = 1'b1;
    raw_level = raw;
    take_rise = tr;
    take_fall = tf;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(step_button(raw, tr, tf));
    n_ticks++;
    @(negedge clk);
  endtask

  // Stop offering and wait until every expected result has come out
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input cfg_t val);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CfgIdxDebounce) debounce_cfg = val;
    else repeat_cfg = val;
    n_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Receiver: random stall, or a long hold-off while holdoff_left runs down
  always @(negedge clk) begin
    if (holdoff_left > 0) begin
      out_stall = 1'b1;
      holdoff_left--;
    end else begin
      out_stall = (recv_stall_pct != 0) && coin(recv_stall_pct);
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    tick_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result beat: pressed=%0b rise=%0b fall=%0b held=%0d",
                   $realtime, pressed, rise_pending, fall_pending, held_ms);
      end else begin
        want = pending_results.pop_front();
        if (want.pressed !== pressed || want.rise !== rise_pending ||
            want.fall !== fall_pending || want.held !== held_ms) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] exp p=%0b r=%0b f=%0b held=%0d, got p=%0b r=%0b f=%0b held=%0d",
                     $realtime, want.pressed, want.rise, want.fall, want.held,
                     pressed, rise_pending, fall_pending, held_ms);
        end
      end
    end
  end

  // Default settings: released with a release event pending, wrong takes ignored
  task automatic test_after_reset();
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b0, 1'b0);
  endtask

  // Zero debounce: a raw change is taken on the same tick
  task automatic test_zero_debounce();
    write_reg(CfgIdxDebounce, '0);
    write_reg(CfgIdxRepeat, '0);
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0);
  endtask

  // Glitches during the debounce wait do not restart the count
  task automatic test_bounce();
    write_reg(CfgIdxDebounce, cfg_t'(3));
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
  endtask

  // Auto-repeat re-arms the press event while held
  task automatic test_repeat();
    write_reg(CfgIdxDebounce, cfg_t'(1));
    write_reg(CfgIdxRepeat, cfg_t'(2));
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
  endtask

  // Largest debounce and repeat: a held press stays off for the whole stretch
  task automatic test_long_extremes();
    write_reg(CfgIdxDebounce, '0);
    write_reg(CfgIdxRepeat, '0);
    send_tick(1'b0, 1'b0, 1'b0);
    write_reg(CfgIdxDebounce, '1);
    write_reg(CfgIdxRepeat, '1);
    repeat (150) send_tick(1'b1, coin(5), coin(5));
  endtask

  // Long receiver hold-off while ticks keep coming, then a drained pause and random stalls
  task automatic test_backpressure();
    write_reg(CfgIdxDebounce, cfg_t'(2));
    write_reg(CfgIdxRepeat, cfg_t'(3));
    holdoff_left = 60;
    repeat (40) send_tick(coin(60), coin(30), coin(30));
    wait_drained();
    recv_stall_pct = 50;
    repeat (20) send_tick(coin(60), coin(30), coin(30));
    recv_stall_pct = 0;
  endtask

  // Mostly clean presses and releases with bounce, plus some pure noise
  task automatic test_random_phase(input int budget, input int send_pct, input int stall_pct);
    int   sent;
    int   seg_len;
    int   dbc;
    int   rpt;
    logic lvl;
    sent = 0;
    dbc  = $urandom_range(8);
    rpt  = coin(25) ? 0 : $urandom_range(1, 12);
    write_reg(CfgIdxDebounce, cfg_t'(dbc));
    write_reg(CfgIdxRepeat, cfg_t'(rpt));
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    while (sent < budget) begin
      if (coin(15)) begin
        seg_len = $urandom_range(1, 6);
        repeat (seg_len) send_tick(coin(50), coin(50), coin(50));
        sent += seg_len;
      end else begin
        lvl     = coin(50);
        seg_len = $urandom_range(0, 4);
        repeat (seg_len) send_tick(coin(50), coin(10), coin(10));
        sent += seg_len;
        seg_len = $urandom_range(1, dbc + rpt + 10);
        repeat (seg_len) send_tick(lvl, coin(30), coin(30));
        sent += seg_len;
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    raw_level    = 1'b0;
    take_rise    = 1'b0;
    take_fall    = 1'b0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CfgIdxDebounce;
    cfg_data     = '0;
    btn_level    = 1'b0;
    btn_ms       = '0;
    btn_taken    = 1'b0;
    debounce_cfg = DebounceRst;
    repeat_cfg   = RepeatRst;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_after_reset();
    test_zero_debounce();
    test_bounce();
    test_repeat();
    test_long_extremes();
    test_backpressure();
    test_random_phase(125, 0, 0);
    test_random_phase(125, 66, 0);
    test_random_phase(125, 0, 66);
    test_random_phase(125, 30, 30);

    wait_drained();
    repeat (10) @(negedge clk);
    $display("Ran %0d ticks (%0d results checked) over %0d register writes,", n_ticks,
             n_checked, n_writes);
    $display("covering debounce, bounce, repeat, wrong takes, extremes and back-pressure.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching beats", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Run timed out with %0d results outstanding", pending_results.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
